/* hdl/assert_macros.svh */
// Assertion helper macros for the calendar converter RTL.
// Included by files that carry concurrent checks; uses clk and rst_n of the includer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CDOY_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("calendar converter check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CDOY_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("calendar converter check failed");

`endif

/* hdl/cdoy_pkg.sv */
// Shared types, constants and month table for the calendar converter.
// No dependencies; used by cdoy_split, cdoy_calc and the top level.
package cdoy_pkg;

  // Field widths
  localparam int DATE_W = 27;
  localparam int YEAR_W = 14;
  localparam int DOY_W  = 9;

  // Decimal limits of an eight-digit date
  localparam logic [DATE_W-1:0] DATE_MIN = 27'd10000000;
  localparam logic [DATE_W-1:0] DATE_MAX = 27'd99999999;

  // Divide by 10000: q = (x * DIV10K_MUL) >> DIV10K_SHIFT, exact for any 27-bit x
  localparam logic [26:0] DIV10K_MUL   = 27'd109951163;
  localparam int          DIV10K_SHIFT = 40;
  localparam logic [13:0] TEN_THOUSAND = 14'd10000;

  // Divide by 100: q = (x * DIV100_MUL) >> DIV100_SHIFT, exact for any 14-bit x
  localparam logic [13:0] DIV100_MUL   = 14'd10486;
  localparam int          DIV100_SHIFT = 20;
  localparam logic [6:0]  HUNDRED      = 7'd100;

  localparam logic [6:0]       MONTH_FIRST = 7'd1;
  localparam logic [6:0]       MONTH_LAST  = 7'd12;
  localparam logic [DOY_W-1:0] YEAR_DAYS   = 9'd365;
  localparam logic [DOY_W-1:0] LEAP_DAYS   = 9'd366;

  // Word handed from the digit-split pipe to the calendar pipe
  typedef struct packed {
    logic              valid;
    logic              mode;
    logic              range_ok;
    logic [YEAR_W-1:0] year;
    logic [1:0]        yhund_lo;   // low bits of year / 100
    logic [6:0]        yrem;       // year % 100
    logic [6:0]        month;      // (date % 10000) / 100
    logic [13:0]       rem;        // date % 10000
    logic [DOY_W-1:0]  doy;
  } cdoy_split_t;

  // Days in months 1..k of a year (k = 0 gives 0)
  function automatic logic [8:0] cum_days(input logic [3:0] k, input logic leap);
    logic [8:0] base;
    case (k)
      4'd0:    base = 9'd0;
      4'd1:    base = 9'd31;
      4'd2:    base = 9'd59;
      4'd3:    base = 9'd90;
      4'd4:    base = 9'd120;
      4'd5:    base = 9'd151;
      4'd6:    base = 9'd181;
      4'd7:    base = 9'd212;
      4'd8:    base = 9'd243;
      4'd9:    base = 9'd273;
      4'd10:   base = 9'd304;
      4'd11:   base = 9'd334;
      default: base = 9'd365;
    endcase
    return base + 9'((leap && (k >= 4'd2)) ? 1 : 0);
  endfunction

endpackage

/* hdl/calendar_day_of_year_converter_top.sv */
// Gregorian date converter: YYYYMMDD to day of year (mode 0), year and day to YYYYMMDD (mode 1).
// Each accepted word passes split stages 1 to 3 and calc stages 4 and 5 before the out_valid strobe, in both modes.
// Throughput: one word per cycle while busy is low; the five-stage multiply pipe never stalls.
// Reset (synchronous, rst_n low) empties the pipe; busy is registered, set by reset and cleared once rst_n is high.
// Depends on cdoy_pkg, cdoy_split, cdoy_calc and assert_macros.svh.
`include "assert_macros.svh"

module calendar_day_of_year_converter_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_mode,
  input  logic [26:0] in_packed_date,
  input  logic [13:0] in_year,
  input  logic [8:0]  in_day_of_year,
  output logic        out_valid,
  output logic [8:0]  out_day_count,
  output logic [26:0] out_date,
  output logic        out_invalid
);
  import cdoy_pkg::*;

  logic        busy_r;
  logic        in_valid;
  cdoy_split_t split_w;

  // Hold off inputs through reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy     = busy_r;
  assign in_valid = start && !busy_r;

  cdoy_split u_split (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_mode        (in_mode),
    .in_packed_date (in_packed_date),
    .in_year        (in_year),
    .in_day_of_year (in_day_of_year),
    .split_o        (split_w)
  );

  cdoy_calc u_calc (
    .clk           (clk),
    .rst_n         (rst_n),
    .split_i       (split_w),
    .out_valid     (out_valid),
    .out_day_count (out_day_count),
    .out_date      (out_date),
    .out_invalid   (out_invalid)
  );

  // Checks
  `CDOY_ASSERT_IMP(a_latency, in_valid, ##5 out_valid)
  `CDOY_ASSERT_IMP(a_no_orphan, out_valid, $past(in_valid, 5))
  `CDOY_ASSERT_IMP(a_invalid_zero, out_valid && out_invalid, out_day_count == 9'd0 && out_date == 27'd0)
  `CDOY_ASSERT_IMP(a_one_mode, out_valid, out_day_count == 9'd0 || out_date == 27'd0)

endmodule

/* hdl/cdoy_split.sv */
// Digit split pipe: three register stages that take the date apart by
// constant reciprocal multiplies (year, month digits, year % 100). Uses cdoy_pkg.
module cdoy_split (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_mode,
  input  logic [26:0]                 in_packed_date,
  input  logic [13:0]                 in_year,
  input  logic [8:0]                  in_day_of_year,
  output cdoy_pkg::cdoy_split_t       split_o
);
  import cdoy_pkg::*;

  // Stage 1 registers
  logic              s1_valid_r, s1_mode_r, s1_range_ok_r;
  logic [DATE_W-1:0] s1_date_r;
  logic [YEAR_W-1:0] s1_year_r, s1_yq_r;
  logic [DOY_W-1:0]  s1_doy_r;
  // Stage 2 registers
  logic              s2_valid_r, s2_mode_r, s2_range_ok_r;
  logic [YEAR_W-1:0] s2_year_r;
  logic [DOY_W-1:0]  s2_doy_r;
  logic [13:0]       s2_rem_r;
  logic [7:0]        s2_yh_r;
  // Stage 3 register
  cdoy_split_t       s3_r, s3_nxt;

  logic [53:0]       prod_10k;
  logic [YEAR_W-1:0] s1_yq_nxt;
  logic [YEAR_W-1:0] year_sel;
  logic [27:0]       back_10k, prod_yh;
  logic [DATE_W-1:0] rem_full;
  logic [27:0]       prod_m;
  logic [13:0]       yh_x100, yrem_full, m_x100;

  // Stage 1: year digits of the packed date
  assign prod_10k  = 54'(in_packed_date) * 54'(DIV10K_MUL);
  assign s1_yq_nxt = prod_10k[DIV10K_SHIFT +: YEAR_W];

  // Stage 2: low four digits, and year / 100 for the leap rule
  assign year_sel = s1_mode_r ? s1_year_r : s1_yq_r;
  assign back_10k = 28'(s1_yq_r) * 28'(TEN_THOUSAND);
  assign rem_full = s1_date_r - back_10k[DATE_W-1:0];
  assign prod_yh  = 28'(year_sel) * 28'(DIV100_MUL);

  // Stage 3: month digits and year % 100
  assign prod_m    = 28'(s2_rem_r) * 28'(DIV100_MUL);
  assign yh_x100   = 14'(s2_yh_r) * 14'(HUNDRED);
  assign yrem_full = s2_year_r - yh_x100;
  assign m_x100    = '0;

  always_comb begin
    s3_nxt          = s3_r;
    s3_nxt.valid    = s2_valid_r;
    s3_nxt.mode     = s2_mode_r;
    s3_nxt.range_ok = s2_range_ok_r;
    s3_nxt.year     = s2_year_r;
    s3_nxt.yhund_lo = s2_yh_r[1:0];
    s3_nxt.yrem     = yrem_full[6:0] | m_x100[6:0];
    s3_nxt.month    = prod_m[DIV100_SHIFT +: 7];
    s3_nxt.rem      = s2_rem_r;
    s3_nxt.doy      = s2_doy_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_r.valid <= 1'b0;
    end else begin
      s1_valid_r <= in_valid;
      s2_valid_r <= s1_valid_r;
      s3_r.valid <= s3_nxt.valid;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk) begin
    s1_mode_r      <= in_mode;
    s1_range_ok_r  <= (in_packed_date >= DATE_MIN) && (in_packed_date <= DATE_MAX);
    s1_date_r      <= in_packed_date;
    s1_year_r      <= in_year;
    s1_doy_r       <= in_day_of_year;
    s1_yq_r        <= s1_yq_nxt;
    s2_mode_r      <= s1_mode_r;
    s2_range_ok_r  <= s1_range_ok_r;
    s2_year_r      <= year_sel;
    s2_doy_r       <= s1_doy_r;
    s2_rem_r       <= rem_full[13:0];
    s2_yh_r        <= prod_yh[DIV100_SHIFT +: 8];
    s3_r.mode      <= s3_nxt.mode;
    s3_r.range_ok  <= s3_nxt.range_ok;
    s3_r.year      <= s3_nxt.year;
    s3_r.yhund_lo  <= s3_nxt.yhund_lo;
    s3_r.yrem      <= s3_nxt.yrem;
    s3_r.month     <= s3_nxt.month;
    s3_r.rem       <= s3_nxt.rem;
    s3_r.doy       <= s3_nxt.doy;
  end

  assign split_o = s3_r;

endmodule

/* hdl/cdoy_calc.sv */
// Calendar pipe: two register stages with the leap rule, checks, month table
// lookups and the packed date assembly. Uses cdoy_pkg.
module cdoy_calc (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cdoy_pkg::cdoy_split_t split_i,
  output logic                  out_valid,
  output logic [8:0]            out_day_count,
  output logic [26:0]           out_date,
  output logic                  out_invalid
);
  import cdoy_pkg::*;

  // Stage 4 registers
  logic              s4_valid_r, s4_mode_r, s4_invalid_r, s4_leap_r;
  logic [6:0]        s4_dd_r;
  logic [3:0]        s4_midx_r, s4_cnt_r;
  logic [DOY_W-1:0]  s4_doy_r;
  logic [DATE_W-1:0] s4_ymul_r;
  // Output registers
  logic              out_valid_r, out_invalid_r;
  logic [8:0]        out_day_count_r, out_day_count_nxt;
  logic [DATE_W-1:0] out_date_r, out_date_nxt;

  logic              leap, month_ok, bad_date, bad_doy;
  logic [13:0]       m_x100, dd_full;
  logic [DOY_W-1:0]  year_len;
  logic [3:0]        cnt;
  logic [27:0]       ymul;
  logic [3:0]        midx;
  logic [8:0]        day_full;
  logic [3:0]        mon;
  logic [DATE_W-1:0] mon_x100;

  // Stage 4: leap rule, checks, day digits, month search for mode 1
  assign leap     = ((split_i.year[1:0] == 2'd0) && (split_i.yrem != 7'd0)) ||
                    ((split_i.yrem == 7'd0) && (split_i.yhund_lo == 2'd0));
  assign month_ok = (split_i.month >= MONTH_FIRST) && (split_i.month <= MONTH_LAST);
  assign bad_date = !split_i.range_ok || !month_ok;
  assign year_len = leap ? LEAP_DAYS : YEAR_DAYS;
  assign bad_doy  = (split_i.doy == '0) || (split_i.doy > year_len);
  assign m_x100   = 14'(split_i.month) * 14'(HUNDRED);
  assign dd_full  = split_i.rem - m_x100;
  assign ymul     = 28'(split_i.year) * 28'(TEN_THOUSAND);
  assign midx     = split_i.month[3:0] - 4'd1;

  // Count month ends that lie before the ordinal day
  always_comb begin
    cnt = '0;
    for (int k = 1; k <= 11; k++) begin
      if (split_i.doy > cum_days(4'(k), leap)) cnt = cnt + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
    end else begin
      s4_valid_r <= split_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    s4_mode_r    <= split_i.mode;
    s4_invalid_r <= split_i.mode ? bad_doy : bad_date;
    s4_leap_r    <= leap;
    s4_dd_r      <= dd_full[6:0];
    s4_midx_r    <= midx;
    s4_cnt_r     <= cnt;
    s4_doy_r     <= split_i.doy;
    s4_ymul_r    <= ymul[DATE_W-1:0];
  end

  // Stage 5: table add for mode 0, date assembly for mode 1
  assign day_full = s4_doy_r - cum_days(s4_cnt_r, s4_leap_r);
  assign mon      = s4_cnt_r + 4'd1;
  assign mon_x100 = 27'(mon) * 27'(HUNDRED);

  always_comb begin
    out_day_count_nxt = '0;
    out_date_nxt      = '0;
    if (!s4_invalid_r) begin
      if (s4_mode_r) begin
        out_date_nxt = s4_ymul_r + mon_x100 + 27'(day_full[4:0]);
      end else begin
        out_day_count_nxt = cum_days(s4_midx_r, s4_leap_r) + 9'(s4_dd_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s4_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    out_invalid_r   <= s4_invalid_r;
    out_day_count_r <= out_day_count_nxt;
    out_date_r      <= out_date_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_invalid   = out_invalid_r;
  assign out_day_count = out_day_count_r;
  assign out_date      = out_date_r;

endmodule
